[rtl/tcw_pkg.sv]
// Shared types, constants and tables for the text console writer.
`default_nettype none
package tcw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;
  localparam int CELLS    = ROWS * COLUMNS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CX_W   = $clog2(COLUMNS + TAB_STOP);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HIGH  = 8'h80;

  localparam logic [7:0]  ATTR_RESET = 8'h0F;
  localparam logic [15:0] RESET_CELL = {ATTR_RESET, CH_SPACE};

  typedef enum logic [2:0] {
    K_NOP,
    K_PUT,
    K_BS,
    K_TAB,
    K_CR,
    K_LF,
    K_CLEAR,
    K_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       ch;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             in_range;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ADDR,
    ST_EXEC,
    ST_READ,
    ST_FILL,
    ST_RESULT
  } back_state_t;

  typedef logic [CX_W-1:0] tab_tbl_t [COLUMNS];

  function automatic tab_tbl_t tab_table();
    tab_tbl_t t;
    for (int c = 0; c < COLUMNS; c++) begin
      t[c] = CX_W'(c + TAB_STOP - (c % TAB_STOP));
    end
    return t;
  endfunction

  localparam tab_tbl_t TAB_NEXT = tab_table();

endpackage
`default_nettype wire

[rtl/tcw_front.sv]
// Front end: accepts input transactions, classifies them and pushes commands to the queue.
`default_nettype none
module tcw_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [1:0]   op,
  input  wire logic [7:0]   char_code,
  input  wire logic [4:0]   read_row,
  input  wire logic [6:0]   read_col,
  input  wire logic         accept_en,
  output logic              q_push,
  output tcw_pkg::cmd_t     q_data,
  input  wire logic         q_full
);
  import tcw_pkg::*;

  cmd_t cmd_in;
  cmd_t hold;
  logic hold_valid;

  always_comb begin
    cmd_in          = '0;
    cmd_in.kind     = K_NOP;
    cmd_in.ch       = char_code;
    cmd_in.row      = ROW_W'(read_row);
    cmd_in.col      = COL_W'(read_col);
    cmd_in.in_range = (int'(read_row) < ROWS) && (int'(read_col) < COLUMNS);
    unique case (op)
      OP_WRITE: begin
        if (char_code == CH_BS) begin
          cmd_in.kind = K_BS;
        end else if (char_code == CH_TAB) begin
          cmd_in.kind = K_TAB;
        end else if (char_code == CH_CR) begin
          cmd_in.kind = K_CR;
        end else if (char_code == CH_LF) begin
          cmd_in.kind = K_LF;
        end else if (char_code >= CH_SPACE && char_code < CH_HIGH) begin
          cmd_in.kind = K_PUT;
        end
      end
      OP_CLEAR: cmd_in.kind = K_CLEAR;
      OP_READ:  cmd_in.kind = K_READ;
      default:  cmd_in.kind = K_NOP;
    endcase
  end

  assign q_push   = hold_valid && !q_full;
  assign in_ready = accept_en && (!hold_valid || !q_full);
  assign q_data   = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (q_push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= cmd_in;
    end
  end

endmodule
`default_nettype wire

[rtl/tcw_fifo.sv]
// Short command queue between the front end and the executor.
`default_nettype none
module tcw_fifo (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  tcw_pkg::cmd_t  push_data,
  output logic           full,
  input  wire logic      pop,
  output tcw_pkg::cmd_t  pop_data,
  output logic           empty
);
  import tcw_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W + 1)'(QDEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
`endif

endmodule
`default_nettype wire

[rtl/tcw_back.sv]
// Executor: screen store, cursor and scroll state, row fill and clear sweeps, result register.
`default_nettype none
module tcw_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   text_attribute,
  input  tcw_pkg::cmd_t     q_data,
  input  wire logic         q_empty,
  output logic              q_pop,
  output logic              accept_en,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [6:0]        cursor_col,
  output logic [4:0]        cursor_row,
  output logic [10:0]       cursor_index,
  output logic [15:0]       cell_value,
  output logic              scrolled
);
  import tcw_pkg::*;

  back_state_t state, state_next;

  cmd_t              cmd;
  logic [7:0]        attr;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  line;
  logic [ROW_W-1:0]  top;
  logic [ROW_W-1:0]  prow;
  logic [ADDR_W-1:0] fill_addr;
  logic [ADDR_W-1:0] fill_last;
  logic              scrolled_r;
  logic [15:0]       cell_r;

  logic [15:0]       mem [CELLS];
  logic [15:0]       rd_data;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [15:0]       mem_wdata;

  logic [ROW_W-1:0]  row_sel;
  logic [ROW_W:0]    prow_sum;
  logic [ROW_W-1:0]  prow_n;
  logic [ADDR_W-1:0] exec_addr;
  logic [ADDR_W-1:0] top_base;
  logic [ROW_W-1:0]  top_inc;
  logic [CX_W-1:0]   col_adv;
  logic              line_adv;
  logic [COL_W-1:0]  col_n;
  logic [ROW_W:0]    line_sum;
  logic              scroll;
  logic              fill_done;
  logic              out_free;

  assign cfg_ready = 1'b1;
  assign accept_en = (state != ST_INIT);
  assign out_free  = !out_valid || out_ready;
  assign fill_done = (fill_addr == fill_last);

  assign row_sel  = (cmd.kind == K_READ) ? cmd.row : line;
  assign prow_sum = {1'b0, row_sel} + {1'b0, top};
  assign prow_n   = (int'(prow_sum) >= ROWS) ? ROW_W'(int'(prow_sum) - ROWS)
                                             : prow_sum[ROW_W-1:0];
  assign exec_addr = ADDR_W'(ADDR_W'(prow) * COLUMNS)
                   + ADDR_W'((cmd.kind == K_READ) ? cmd.col : col);
  assign top_base  = ADDR_W'(ADDR_W'(top) * COLUMNS);
  assign top_inc   = (int'(top) == ROWS - 1) ? '0 : top + 1'b1;

  // cursor movement for one character
  always_comb begin
    col_adv  = CX_W'(col);
    line_adv = 1'b0;
    case (cmd.kind)
      K_BS:    col_adv = (col != '0) ? CX_W'(col - 1'b1) : CX_W'(col);
      K_TAB:   col_adv = TAB_NEXT[col];
      K_CR:    col_adv = '0;
      K_LF: begin
        col_adv  = '0;
        line_adv = 1'b1;
      end
      K_PUT:   col_adv = CX_W'(col) + 1'b1;
      default: col_adv = CX_W'(col);
    endcase
    if (int'(col_adv) >= COLUMNS) begin
      col_n    = '0;
      line_adv = 1'b1;
    end else begin
      col_n = col_adv[COL_W-1:0];
    end
    line_sum = {1'b0, line} + (ROW_W + 1)'(line_adv);
    scroll   = (int'(line_sum) >= ROWS);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:   if (fill_done) state_next = ST_IDLE;
      ST_IDLE:   if (!q_empty) state_next = ST_ADDR;
      ST_ADDR:   state_next = ST_EXEC;
      ST_EXEC: begin
        if (cmd.kind == K_CLEAR) begin
          state_next = ST_FILL;
        end else if (cmd.kind == K_READ) begin
          state_next = cmd.in_range ? ST_READ : ST_RESULT;
        end else begin
          state_next = scroll ? ST_FILL : ST_RESULT;
        end
      end
      ST_READ:   state_next = ST_RESULT;
      ST_FILL:   if (fill_done) state_next = ST_RESULT;
      ST_RESULT: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = exec_addr;
    mem_wdata = {attr, cmd.ch};
    unique case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_addr  = fill_addr;
        mem_wdata = RESET_CELL;
      end
      ST_IDLE:  q_pop = !q_empty;
      ST_EXEC: begin
        mem_we = (cmd.kind == K_PUT);
        mem_re = (cmd.kind == K_READ) && cmd.in_range;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_addr  = fill_addr;
        mem_wdata = {attr, CH_SPACE};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      attr <= text_attribute;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      col        <= '0;
      line       <= '0;
      top        <= '0;
      fill_addr  <= '0;
      fill_last  <= ADDR_W'(CELLS - 1);
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_INIT: begin
          fill_addr <= fill_addr + 1'b1;
        end
        ST_IDLE: begin
          if (!q_empty) begin
            cmd        <= q_data;
            scrolled_r <= 1'b0;
            cell_r     <= '0;
          end
        end
        ST_ADDR: begin
          prow <= prow_n;
        end
        ST_EXEC: begin
          if (cmd.kind == K_CLEAR) begin
            fill_addr <= '0;
            fill_last <= ADDR_W'(CELLS - 1);
          end else if (cmd.kind != K_READ) begin
            col <= col_n;
            if (!scroll) begin
              line <= line_sum[ROW_W-1:0];
            end
            fill_addr <= top_base;
            fill_last <= top_base + ADDR_W'(COLUMNS - 1);
          end
        end
        ST_READ: begin
          cell_r <= rd_data;
        end
        ST_FILL: begin
          fill_addr <= fill_addr + 1'b1;
          if (fill_done) begin
            if (cmd.kind == K_CLEAR) begin
              top  <= '0;
              col  <= '0;
              line <= '0;
            end else begin
              top        <= top_inc;
              line       <= ROW_W'(ROWS - 1);
              scrolled_r <= 1'b1;
            end
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            cursor_col   <= 7'(col);
            cursor_row   <= 5'(line);
            cursor_index <= 11'(int'(line) * COLUMNS + int'(col));
            cell_value   <= cell_r;
            scrolled     <= scrolled_r;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_col_range: assert property (@(posedge clk) disable iff (rst) int'(col) < COLUMNS)
    else $error("cursor column out of range");
  a_line_range: assert property (@(posedge clk) disable iff (rst) int'(line) < ROWS)
    else $error("cursor line out of range");
  a_top_range: assert property (@(posedge clk) disable iff (rst) int'(top) < ROWS)
    else $error("top row offset out of range");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
      (state == ST_FILL || state == ST_INIT) |-> fill_addr <= fill_last)
    else $error("fill sweep ran past its last cell");
`endif

endmodule
`default_nettype wire

[rtl/text_console_writer.sv]
// Top level of the text console writer: front end, command queue and executor.
// After reset the screen store is swept to blank cells (attribute 0x0F), one cell a cycle,
// during which in_ready stays low. A transaction is then taken into a four-entry command
// queue, and the executor, which owns the single-port screen memory, handles one command at
// a time: a character, backspace, tab, CR, LF or ignored code steps through the idle, address,
// execute and result states, an in-range cell read adds a read state (registered memory read),
// a step that scrolls adds a sweep to blank the recycled row, and a clear a sweep to blank every cell.
// The result register lets the next command start while a result waits to be taken.
`default_nettype none
module text_console_writer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [7:0]  char_code,
  input  wire logic [4:0]  read_row,
  input  wire logic [6:0]  read_col,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  text_attribute,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       cursor_col,
  output logic [4:0]       cursor_row,
  output logic [10:0]      cursor_index,
  output logic [15:0]      cell_value,
  output logic             scrolled
);
  import tcw_pkg::*;

  cmd_t front_cmd;
  cmd_t q_head;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  logic accept_en;

  tcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .char_code (char_code),
    .read_row  (read_row),
    .read_col  (read_col),
    .accept_en (accept_en),
    .q_push    (q_push),
    .q_data    (front_cmd),
    .q_full    (q_full)
  );

  tcw_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_head),
    .empty     (q_empty)
  );

  tcw_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .text_attribute (text_attribute),
    .q_data         (q_head),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .accept_en      (accept_en),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cursor_col     (cursor_col),
    .cursor_row     (cursor_row),
    .cursor_index   (cursor_index),
    .cell_value     (cell_value),
    .scrolled       (scrolled)
  );

endmodule
`default_nettype wire
